/* hw/rtl/mbd_pkg.sv */
// Package for the mipmap 2x2 box downsampler: widths, register codes, lane arithmetic.
`default_nettype none

package mbd_pkg;

  localparam int unsigned PIX_W        = 32;
  localparam int unsigned LANE_W       = 8;
  localparam int unsigned LANES        = 4;
  localparam int unsigned SUM_W        = 9;
  localparam int unsigned PAIR_W       = LANES * SUM_W;
  localparam int unsigned CFG_W        = 11;
  localparam int unsigned ROW_W        = 11;
  localparam int unsigned HEIGHT_LIMIT = 1024;

  localparam logic REG_DEST_WIDTH  = 1'b0;
  localparam logic REG_DEST_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [PAIR_W-1:0] pair_t;

  // per-lane sum of two pixels, four 9-bit lanes
  function automatic pair_t lane_pair(input pix_t a, input pix_t b);
    pair_t r;
    r = '0;
    for (int k = 0; k < LANES; k++) begin
      r[k*SUM_W +: SUM_W] = {1'b0, a[k*LANE_W +: LANE_W]} + {1'b0, b[k*LANE_W +: LANE_W]};
    end
    return r;
  endfunction

  // per-lane floor of the 2x2 mean from two pair sums
  function automatic pix_t lane_avg(input pair_t p, input pair_t q);
    pix_t                r;
    logic [SUM_W:0]      s;
    r = '0;
    for (int k = 0; k < LANES; k++) begin
      s = {1'b0, p[k*SUM_W +: SUM_W]} + {1'b0, q[k*SUM_W +: SUM_W]};
      r[k*LANE_W +: LANE_W] = s[LANE_W+1:2];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/mbd_ram.sv */
// Generic single-clock RAM, one write port and one registered read port.
`default_nettype none

module mbd_ram #(
  parameter int unsigned WIDTH = 36,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/mipmap_box_downsampler_top.sv */
// Top level of the mipmap 2x2 box downsampler.
// Takes 32-bit source pixels (four 8-bit lanes) in raster order from an image of
// 2*dest_width by 2*dest_height and emits one destination pixel per 2x2 block,
// each lane the truncated mean, with tlast on the last pixel of a frame. One source
// pixel is taken per cycle while the input does not stall; the result is registered
// in a line RAM read stage, then in the output register, once the pixel completing
// its block is accepted. The input stalls only while both stages hold words and
// m_axis_tready is low. Even source rows store horizontal pair sums in a line RAM of
// MAX_DEST_WIDTH entries, odd rows read them back, one RAM access per pixel pair.
// The line RAM needs no clearing. Write dest_width and dest_height only while idle.
`default_nettype none

module mipmap_box_downsampler_top #(
  parameter int unsigned MAX_DEST_WIDTH = 1024,
  localparam int unsigned EFF_MAX = (MAX_DEST_WIDTH < 2047) ? MAX_DEST_WIDTH : 2047,
  localparam int unsigned COL_W   = $clog2(2 * EFF_MAX),
  localparam int unsigned IDX_W   = (MAX_DEST_WIDTH > 1) ? $clog2(MAX_DEST_WIDTH) : 1
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic                       cfg_index_i,
  input  wire logic [mbd_pkg::CFG_W-1:0]  cfg_data_i,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [mbd_pkg::PIX_W-1:0]  s_axis_tdata,   // src_pixel [31:0]
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic      [mbd_pkg::PIX_W-1:0]  m_axis_tdata,   // out_pixel [31:0]
  output logic                            m_axis_tlast    // frame_last
);

  import mbd_pkg::*;

  logic [CFG_W-1:0] width_q, height_q;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  pix_t             held_q;
  logic             s1_v_q;
  pair_t            s1_pair_q;
  logic             s1_last_q;
  logic             out_v_q;
  pix_t             out_pix_q;
  logic             out_last_q;

  logic [CFG_W-1:0] w_clamp, h_clamp;
  logic [COL_W-1:0] eff_w;
  logic             row_end, frame_end, accept, advance;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] idx;
  pair_t            pair, above;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(1);
      height_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_DEST_WIDTH:  width_q  <= cfg_data_i;
        REG_DEST_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      w_clamp = CFG_W'(1);
    end else if (width_q > CFG_W'(EFF_MAX)) begin
      w_clamp = CFG_W'(EFF_MAX);
    end else begin
      w_clamp = width_q;
    end
    if (height_q == '0) begin
      h_clamp = CFG_W'(1);
    end else if (height_q > CFG_W'(HEIGHT_LIMIT)) begin
      h_clamp = CFG_W'(HEIGHT_LIMIT);
    end else begin
      h_clamp = height_q;
    end
  end

  assign eff_w     = COL_W'(w_clamp);
  assign row_end   = ({1'b0, col_q} + (COL_W+1)'(1)) >= {eff_w, 1'b0};
  assign frame_end = row_end && (({1'b0, row_q} + (ROW_W+1)'(1)) >= {h_clamp, 1'b0});

  // flow control: s1 waits on the output register, output register on the sink
  assign advance       = !out_v_q || m_axis_tready;
  assign s_axis_tready = !s1_v_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (row_end) begin
        col_d = '0;
        row_d = frame_end ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  // even rows write the pair sum, odd rows read it back; entries are never
  // touched by adjacent pixels, so no forwarding is needed
  assign idx    = IDX_W'(col_q >> 1);
  assign pair   = lane_pair(held_q, s_axis_tdata);
  assign mem_we = accept && col_q[0] && !row_q[0];
  assign mem_re = accept && col_q[0] && row_q[0];

  mbd_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (MAX_DEST_WIDTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (idx),
    .wdata_i (pair),
    .re_i    (mem_re),
    .raddr_i (idx),
    .rdata_o (above)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      held_q  <= '0;
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (accept && !col_q[0]) begin
        held_q <= s_axis_tdata;
      end
      if (mem_re) begin
        s1_v_q <= 1'b1;
      end else if (advance) begin
        s1_v_q <= 1'b0;
      end
      if (advance) begin
        out_v_q <= s1_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      s1_pair_q <= pair;
      s1_last_q <= frame_end;
    end
    if (advance && s1_v_q) begin
      out_pix_q  <= lane_avg(s1_pair_q, above);
      out_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tlast  = out_last_q;

  a_read_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |=> s1_v_q)
    else $error("line read not followed by a valid s1 stage");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && out_v_q && !m_axis_tready) |=> (s1_v_q && $stable(s1_pair_q)
      && $stable(above)))
    else $error("stalled s1 stage lost its word");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && frame_end) |=> (col_q == '0 && row_q == '0))
    else $error("position did not wrap at frame end");

  a_one_access: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> (row_q[0] && col_q[0] && !mem_we))
    else $error("line read outside an odd row and column");

endmodule

`default_nettype wire
